// ===== hdl/u2da_pkg.sv =====
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared types and constants for the unsigned-to-decimal ASCII converter.
// ----------------------------------------------------------------------------
package u2da_pkg;

    // Width of the binary number that is converted
    localparam int VALUE_WIDTH = 32;
    // Width of the input port field
    localparam int IN_W        = 32;
    // Width of one output character
    localparam int CHAR_W      = 6;
    // Decimal digits of 2^VALUE_WIDTH - 1: floor(W * log10(2)) + 1
    localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
    // Counter widths
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int REM_W       = $clog2(NUM_DIGITS + 1);

    // ASCII code of '0', truncated to the character width
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    // Commands broadcast to every digit cell
    typedef struct packed {
        logic clear;       // zero the digit
        logic bit_shift;   // add-3 correction, then shift one binary bit in
        logic digit_shift; // take the whole digit from the lower neighbor
    } cell_ctrl_t;

endpackage

// ===== hdl/u2da_digit_cell.sv =====
// ----------------------------------------------------------------------------
// u2da_digit_cell
// One BCD digit of the shift-add-3 chain. Corrects and shifts one bit per
// conversion cycle, and passes whole digits upward while results go out.
// ----------------------------------------------------------------------------
module u2da_digit_cell
    import u2da_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       bit_in,
    input  logic [3:0] digit_in,
    output logic       bit_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add 3 when the digit would overflow past 9 after doubling
    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    assign bit_out = adj[3];
    assign digit   = digit_reg;

    // Digit update
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.bit_shift)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.digit_shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== hdl/unsigned_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// Converts an unsigned binary number to its decimal ASCII digits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value) takes one number per
//   transaction. Output channel (out_valid/out_ready, digit_char, last)
//   delivers one ASCII digit per transaction, most significant first, with
//   no leading zeros; zero gives a single '0'. last marks the final digit.
// Timing:
//   One number at a time. After acceptance, a row of NUM_DIGITS BCD cells
//   runs shift-add-3 over all VALUE_WIDTH bits, one bit per cycle. Then the
//   cells shift all NUM_DIGITS digits out toward the top cell, one per
//   cycle while the output register is free; leading zeros are dropped.
// Stalls:
//   A digit waits in the output register while out_ready is low; the cell
//   row holds its contents until the register frees up. in_ready is high
//   only while no number is in work.
// Reset:
//   rst_n clears the controller and the output valid; no state is kept
//   between numbers.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii
    import u2da_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [IN_W-1:0]   value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last
);

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   started_reg, started_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    cell_ctrl_t             ctrl;
    logic [NUM_DIGITS-1:0]  carry;
    logic [3:0]             digits [NUM_DIGITS];
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   is_final;
    logic                   emit_step;
    logic                   produce;
    logic                   accept;

    // Cell row: cell 0 is the least significant digit
    genvar i;
    generate
        for (i = 0; i < NUM_DIGITS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                u2da_digit_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (bin_reg[VALUE_WIDTH-1]),
                    .digit_in (4'd0),
                    .bit_out  (carry[i]),
                    .digit    (digits[i])
                );
            end
            else
            begin : g_rest
                u2da_digit_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (carry[i-1]),
                    .digit_in (digits[i-1]),
                    .bit_out  (carry[i]),
                    .digit    (digits[i])
                );
            end
        end
    endgenerate

    assign top_digit = digits[NUM_DIGITS-1];
    assign out_free  = !out_valid_reg || out_ready;
    assign is_final  = (rem_reg == REM_W'(1));
    assign accept    = in_valid && in_ready;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && is_final)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_ready         = 1'b0;
        ctrl.clear       = 1'b0;
        ctrl.bit_shift   = 1'b0;
        ctrl.digit_shift = 1'b0;
        emit_step        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.clear = in_valid;
            end
            ST_CONVERT:
            begin
                ctrl.bit_shift = 1'b1;
            end
            ST_EMIT:
            begin
                emit_step        = out_free;
                ctrl.digit_shift = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // A digit is sent unless it is a leading zero
    assign produce = emit_step && ((top_digit != 4'd0) || started_reg || is_final);

    // Datapath next values
    always_comb
    begin
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        if (accept)
        begin
            bin_next     = VALUE_WIDTH'(value);
            cnt_next     = CNT_W'(VALUE_WIDTH);
            rem_next     = REM_W'(NUM_DIGITS);
            started_next = 1'b0;
        end
        if (ctrl.bit_shift)
        begin
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (emit_step)
        begin
            rem_next = rem_reg - REM_W'(1);
        end
        if (produce)
        begin
            started_next   = 1'b1;
            out_valid_next = 1'b1;
            char_next      = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
            last_next      = is_final;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            started_reg   <= started_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

endmodule
